// ===== sv/pstz_pkg.sv =====
// ----------------------------------------------------------------------------
// pstz_pkg
// Shared types, widths and helpers for the pairs spread z-score trader.
// ----------------------------------------------------------------------------
package pstz_pkg;

  // Field and state widths
  localparam int PriceW  = 24;  // price port width
  localparam int SpreadW = 25;  // signed spread
  localparam int WinW    = 7;   // window length register
  localparam int ThrW    = 4;   // threshold register
  localparam int PosW    = 8;   // signed position
  localparam int SumW    = 32;  // signed running sum of spreads
  localparam int SqW     = 56;  // running sum of squared spreads
  localparam int DiffW   = 34;  // signed n*s - S
  localparam int MulW    = 34;  // shared multiplier operand width
  localparam int AccW    = 72;  // wide accumulator
  localparam int DevW    = 62;  // n*Q - S*S
  localparam int CashW   = 48;  // cash and marked value

  // Register indexes of the configuration port
  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MAX_POS   = 2'd2;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_LONG  = 2'd1,
    ACT_SHORT = 2'd2
  } action_t;

  // Clamp a 50-bit signed value to the signed 48-bit range
  function automatic logic signed [CashW-1:0] sat48(input logic signed [49:0] v);
    logic signed [49:0] top;
    logic signed [49:0] bot;
    top = 50'sh0_7FFF_FFFF_FFFF;
    bot = -top - 50'sd1;
    if (v > top) begin
      sat48 = top[CashW-1:0];
    end else if (v < bot) begin
      sat48 = bot[CashW-1:0];
    end else begin
      sat48 = v[CashW-1:0];
    end
  endfunction

endpackage

// ===== sv/pairs_spread_zscore_trader.sv =====
// ----------------------------------------------------------------------------
// pairs_spread_zscore_trader
// Rolling z-score pairs trading signal with position and cash tracking.
// ----------------------------------------------------------------------------
// One 34x34 multiplier with a 72-bit accumulator is stepped by a one-hot
// sequencer through the squares, the n*s product, the n*Q and S*S terms,
// the threshold product and the mark-to-market product, one product per
// cycle. The input stalls while an item is in work and while a finished
// result waits for the output register. The sequencer returns to idle on
// the edge that loads the result, and the next item can be accepted in the
// following cycle.
// The spread ring is a single-port array of MAX_WINDOW entries, read in the
// accept cycle and written in the cycle after.
module pairs_spread_zscore_trader #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [pstz_pkg::WinW-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pstz_pkg::PriceW-1:0]     close_first,
  input  logic [pstz_pkg::PriceW-1:0]     close_second,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      action,
  output logic                            window_full,
  output logic signed [pstz_pkg::PosW-1:0]  held_units,
  output logic signed [pstz_pkg::CashW-1:0] cash_total,
  output logic signed [pstz_pkg::CashW-1:0] marked_value
);
  import pstz_pkg::*;

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = ((AW > WinW) ? AW : WinW) + 1;
  localparam int MAXN  = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
  localparam logic [WinW-1:0] MaxN7 = WinW'(MAXN);
  localparam logic [PriceW-1:0] PMask =
    (PRICE_BITS >= PriceW) ? {PriceW{1'b1}} : PriceW'((33'd1 << PRICE_BITS) - 33'd1);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_OLD   = 14'b00000000000010,
    ST_NEW   = 14'b00000000000100,
    ST_NS    = 14'b00000000001000,
    ST_SS    = 14'b00000000010000,
    ST_NQLO  = 14'b00000000100000,
    ST_NQHI  = 14'b00000001000000,
    ST_DD    = 14'b00000010000000,
    ST_RLO   = 14'b00000100000000,
    ST_RHI   = 14'b00001000000000,
    ST_CMP   = 14'b00010000000000,
    ST_TRADE = 14'b00100000000000,
    ST_MV    = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [WinW-1:0] window_length;
  logic [ThrW-1:0] entry_threshold;
  logic [WinW-1:0] max_position;

  // Window state
  logic signed [SpreadW-1:0] ring [MAX_WINDOW];
  logic [AW-1:0]             ring_pointer;
  logic [WinW-1:0]           items_seen;
  logic signed [SumW-1:0]    spread_sum;
  logic [SqW-1:0]            spread_square_sum;
  logic signed [PosW-1:0]    position_units;
  logic signed [CashW-1:0]   cash_balance;

  // Per-item working registers
  logic signed [SpreadW-1:0] spread;
  logic signed [SpreadW-1:0] old_spread;
  logic [AW-1:0]             slot;
  logic                      full;
  logic signed [DiffW-1:0]   diff;
  logic [2*MulW-1:0]         diff_sq;
  logic [DevW-1:0]           dev;
  logic signed [AccW-1:0]    acc;
  logic [2*MulW-1:0]         prod;
  logic [1:0]                act;

  // Shared multiplier operands
  logic [MulW-1:0] mul_a, mul_b;

  // Derived values
  logic [WinW-1:0]         n_eff;
  logic [CW-1:0]           ptr_x, n_x, slot_inc;
  logic [AW-1:0]           slot_c;
  logic [7:0]              thr_sq;
  logic [SpreadW-2:0]      s_mag, old_mag;
  logic [SumW-1:0]         sum_mag;
  logic [DiffW-1:0]        diff_mag;
  logic [PosW-2:0]         pos_mag;
  logic signed [DiffW-1:0] ns_signed;
  logic signed [DiffW-1:0] sum_ext;
  logic signed [DiffW-1:0] prod_pos;
  logic signed [49:0]      cash_sum, mv_sum;
  logic                    beyond;
  logic signed [PosW-1:0]  lim;
  logic                    accept_in;

  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);

  // Effective window length and ring slot
  always_comb begin
    if (window_length == '0) begin
      n_eff = WinW'(1);
    end else if (window_length > MaxN7) begin
      n_eff = MaxN7;
    end else begin
      n_eff = window_length;
    end
    ptr_x    = CW'(ring_pointer);
    n_x      = CW'(n_eff);
    slot_c   = (ptr_x < n_x) ? ring_pointer : '0;
    slot_inc = CW'(slot) + CW'(1);
  end

  // Magnitudes for the unsigned multiplier
  always_comb begin
    thr_sq   = 8'(entry_threshold) * 8'(entry_threshold);
    s_mag    = spread[SpreadW-1] ? (SpreadW-1)'(-spread) : spread[SpreadW-2:0];
    old_mag  = old_spread[SpreadW-1] ? (SpreadW-1)'(-old_spread)
                                     : old_spread[SpreadW-2:0];
    sum_mag  = spread_sum[SumW-1] ? SumW'(-spread_sum) : SumW'(spread_sum);
    diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    pos_mag  = position_units[PosW-1] ? (PosW-1)'(-position_units)
                                      : position_units[PosW-2:0];
  end

  // Select the multiplier operands for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_OLD: begin
        mul_a = MulW'(old_mag);
        mul_b = MulW'(old_mag);
      end
      ST_NEW: begin
        mul_a = MulW'(s_mag);
        mul_b = MulW'(s_mag);
      end
      ST_NS: begin
        mul_a = MulW'(n_eff);
        mul_b = MulW'(s_mag);
      end
      ST_SS: begin
        mul_a = MulW'(sum_mag);
        mul_b = MulW'(sum_mag);
      end
      ST_NQLO: begin
        mul_a = MulW'(n_eff);
        mul_b = spread_square_sum[MulW-1:0];
      end
      ST_NQHI: begin
        mul_a = MulW'(n_eff);
        mul_b = MulW'(spread_square_sum[SqW-1:MulW]);
      end
      ST_DD: begin
        mul_a = diff_mag;
        mul_b = diff_mag;
      end
      ST_RLO: begin
        mul_a = acc[MulW-1:0];
        mul_b = MulW'(thr_sq);
      end
      ST_RHI: begin
        mul_a = MulW'(dev[DevW-1:MulW]);
        mul_b = MulW'(thr_sq);
      end
      ST_MV: begin
        mul_a = MulW'(pos_mag);
        mul_b = MulW'(s_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Arithmetic that consumes the registered product
  always_comb begin
    ns_signed = spread[SpreadW-1] ? -$signed(DiffW'(prod[30:0]))
                                  : $signed(DiffW'(prod[30:0]));
    sum_ext   = DiffW'(spread_sum);
    prod_pos  = (position_units[PosW-1] ^ spread[SpreadW-1])
                ? -$signed(DiffW'(prod[31:0])) : $signed(DiffW'(prod[31:0]));
    lim       = $signed({1'b0, max_position});
    beyond    = (dev != '0) && (diff != '0) && ($signed(AccW'(diff_sq)) > acc);
    cash_sum  = 50'(cash_balance) + (spread[SpreadW-1] ? 50'(-spread) : -50'(s_mag));
    if (!spread[SpreadW-1]) begin
      cash_sum = 50'(cash_balance) - 50'(spread);
    end
    mv_sum    = 50'(cash_balance) + 50'(prod_pos);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept_in) state_next = ST_OLD;
      ST_OLD:   state_next = ST_NEW;
      ST_NEW:   state_next = ST_NS;
      ST_NS:    state_next = ST_SS;
      ST_SS:    state_next = ST_NQLO;
      ST_NQLO:  state_next = ST_NQHI;
      ST_NQHI:  state_next = ST_DD;
      ST_DD:    state_next = ST_RLO;
      ST_RLO:   state_next = ST_RHI;
      ST_RHI:   state_next = ST_CMP;
      ST_CMP:   state_next = ST_TRADE;
      ST_TRADE: state_next = ST_MV;
      ST_MV:    state_next = ST_DONE;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Spread ring: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept_in) begin
      old_spread <= ring[slot_c];
    end
    if (state == ST_OLD) begin
      ring[slot] <= spread;
    end
  end

  // Payload working registers
  always_ff @(posedge clk) begin
    if (state != ST_IDLE && state != ST_DONE) begin
      prod <= mul_a * mul_b;
    end
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          spread <= $signed({1'b0, close_first & PMask})
                  - $signed({1'b0, close_second & PMask});
          slot   <= slot_c;
          full   <= (items_seen >= n_eff);
        end
      end
      ST_SS: begin
        diff <= ns_signed - sum_ext;
      end
      ST_NQLO: begin
        acc <= -$signed(AccW'(prod));
      end
      ST_NQHI: begin
        acc <= acc + $signed(AccW'(prod));
      end
      ST_DD: begin
        acc <= acc + $signed(AccW'(prod) << MulW);
      end
      ST_RLO: begin
        diff_sq <= prod;
        dev     <= acc[DevW-1:0];
      end
      ST_RHI: begin
        acc <= $signed(AccW'(prod));
      end
      ST_CMP: begin
        acc <= acc + $signed(AccW'(prod) << MulW);
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      window_length     <= WinW'(20);
      entry_threshold   <= ThrW'(2);
      max_position      <= WinW'(5);
      ring_pointer      <= '0;
      items_seen        <= '0;
      spread_sum        <= '0;
      spread_square_sum <= '0;
      position_units    <= '0;
      cash_balance      <= '0;
      act               <= ACT_NONE;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes; a new window length restarts the window
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW: begin
            window_length     <= cfg_data;
            ring_pointer      <= '0;
            items_seen        <= '0;
            spread_sum        <= '0;
            spread_square_sum <= '0;
          end
          REG_THRESHOLD: entry_threshold <= cfg_data[ThrW-1:0];
          REG_MAX_POS:   max_position    <= cfg_data;
          default: begin
          end
        endcase
      end

      // Raise valid when a result is loaded, drop it once taken
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_OLD: begin
          spread_sum <= spread_sum - (full ? SumW'(old_spread) : '0) + SumW'(spread);
          if (!full) begin
            items_seen <= items_seen + WinW'(1);
          end
          ring_pointer <= (slot_inc >= n_x) ? '0 : AW'(slot_inc);
        end
        ST_NEW: begin
          if (full) begin
            spread_square_sum <= spread_square_sum - SqW'(prod[47:0]);
          end
        end
        ST_NS: begin
          spread_square_sum <= spread_square_sum + SqW'(prod[47:0]);
        end
        ST_TRADE: begin
          if (full && beyond && diff[DiffW-1] && (position_units < lim)) begin
            position_units <= position_units + PosW'(1);
            cash_balance   <= sat48(cash_sum);
            act            <= ACT_LONG;
          end else if (full && beyond && !diff[DiffW-1] && (position_units > -lim)) begin
            position_units <= position_units - PosW'(1);
            cash_balance   <= sat48(50'(cash_balance) + 50'(spread));
            act            <= ACT_SHORT;
          end else begin
            act            <= ACT_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register when the slot is free
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      action       <= act;
      window_full  <= full;
      held_units   <= position_units;
      cash_total   <= cash_balance;
      marked_value <= sat48(mv_sum);
    end
  end

endmodule
